// ----- sv/dafmt_pkg.sv -----
package dafmt_pkg;

    localparam int VALUE_W   = 32;
    localparam int SEL_W     = 2;
    localparam int CHAR_W    = 6;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int STEP_W    = 5;
    localparam int IDX_W     = 4;

    // Width select codes
    localparam logic [SEL_W-1:0] SEL_8BIT  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_16BIT = 2'd1;

    // Last double-dabble step (one step per value bit)
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic shift_done;
        logic emit_last;
        logic out_free;
    } dp_status_t;

    // Index of the most significant field position, counted from the units digit
    function automatic logic [IDX_W-1:0] top_index(input logic [SEL_W-1:0] sel);
        logic [IDX_W-1:0] idx;
        case (sel)
            SEL_8BIT:  idx = 4'd2;
            SEL_16BIT: idx = 4'd4;
            default:   idx = 4'd9;
        endcase
        return idx;
    endfunction

endpackage

// ----- sv/dafmt_in_if.sv -----
interface dafmt_in_if;
    import dafmt_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [SEL_W-1:0]   width_select;
    logic               left_aligned;

    modport source (output valid, output value, output width_select, output left_aligned,
                    input ready);
    modport sink   (input valid, input value, input width_select, input left_aligned,
                    output ready);
endinterface

// ----- sv/dafmt_out_if.sv -----
interface dafmt_out_if;
    import dafmt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- sv/dafmt_ctrl.sv -----
module dafmt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dafmt_pkg::dp_status_t status,
    output dafmt_pkg::ctrl_cmd_t  cmd
);
    import dafmt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.shift_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
                if (status.out_free && status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/dafmt_datapath.sv -----
module dafmt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dafmt_pkg::VALUE_W-1:0] in_value,
    input  logic [dafmt_pkg::SEL_W-1:0]   in_width_select,
    input  logic                          in_left_aligned,
    input  dafmt_pkg::ctrl_cmd_t          cmd,
    output dafmt_pkg::dp_status_t         status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dafmt_pkg::CHAR_W-1:0]  out_character,
    output logic                          out_last
);
    import dafmt_pkg::*;

    logic [VALUE_W-1:0] bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               seen_reg;
    logic               left_reg;
    logic               oval_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [VALUE_W-1:0] masked;
    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         digit;
    logic               is_space;
    logic               show;
    logic [CHAR_W-1:0]  char_next;
    logic               oval_next;

    // Cut the value to the selected width
    always_comb
    begin
        case (in_width_select)
            SEL_8BIT:  masked = {24'd0, in_value[7:0]};
            SEL_16BIT: masked = {16'd0, in_value[15:0]};
            default:   masked = in_value;
        endcase
    end

    // Double dabble: add 3 to every digit at 5 or above before the shift
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // Character of the current field position
    always_comb
    begin
        digit     = 4'(bcd_reg >> {idx_reg, 2'b00});
        is_space  = !seen_reg && (digit == 4'd0) && (idx_reg != '0);
        show      = !(left_reg && is_space);
        char_next = is_space ? CHAR_SPACE : (CHAR_ZERO + {2'b00, digit});
    end

    assign status.shift_done = (step_reg == LAST_STEP);
    assign status.emit_last  = (idx_reg == '0);
    assign status.out_free   = !oval_reg || out_ready;

    // Conversion and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg  <= masked;
            bcd_reg  <= '0;
            step_reg <= '0;
            idx_reg  <= top_index(in_width_select);
            seen_reg <= 1'b0;
            left_reg <= in_left_aligned;
        end
        else if (cmd.shift)
        begin
            {bcd_reg, bin_reg} <= {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
            step_reg           <= step_reg + 1'b1;
        end
        else if (cmd.emit)
        begin
            idx_reg  <= idx_reg - 1'b1;
            seen_reg <= seen_reg || !is_space;
        end
    end

    // Output register
    always_comb
    begin
        oval_next = oval_reg && !out_ready;
        if (cmd.emit && show)
        begin
            oval_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oval_reg <= 1'b0;
        end
        else
        begin
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && show)
        begin
            char_reg <= char_next;
            last_reg <= (idx_reg == '0);
        end
    end

    assign out_valid     = oval_reg;
    assign out_character = char_reg;
    assign out_last      = last_reg;

endmodule

// ----- sv/decimal_ascii_formatter.sv -----
// Decimal ASCII formatter: one item at a time.
// After the input transfer, 32 double-dabble shifts run (one per value bit), then the first
// field position is loaded into the output register.
// Each item has P = 3, 5 or 10 field positions, scanned one position per cycle while the
// output is free (skipped spaces too); input is accepted again the cycle after the last.
// Reset: rst_n clears the controller state and output valid flag.
module decimal_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    dafmt_in_if.sink    din,
    dafmt_out_if.source dout
);
    import dafmt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    dafmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .status   (status),
        .cmd      (cmd)
    );

    dafmt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_value        (din.value),
        .in_width_select (din.width_select),
        .in_left_aligned (din.left_aligned),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (dout.valid),
        .out_ready       (dout.ready),
        .out_character   (dout.character),
        .out_last        (dout.last)
    );

endmodule

// ----- bench/decimal_ascii_formatter_tb.sv -----
module decimal_ascii_formatter_tb;
    import dafmt_pkg::*;

    // Width codes the package leaves unnamed
    localparam logic [SEL_W-1:0] SEL_32BIT = 2'd2;
    localparam logic [SEL_W-1:0] SEL_SPARE = 2'd3;

    localparam int RANDOM_NUMBERS = 270;
    localparam int SETTLE_CYCLES  = 60;
    localparam int CYCLE_LIMIT    = 1_000_000;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [SEL_W-1:0]   width_select;
        logic               left_aligned;
        bit                 drain_first;
    } number_req_t;

    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              last;
    } char_out_t;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic clk;
    logic rst_n;

    dafmt_in_if  din_bus ();
    dafmt_out_if dout_bus ();

    number_req_t pending_numbers[$];
    char_out_t   pending_chars[$];
    int          mismatches;
    int          cycle_count;

    decimal_ascii_formatter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_bus),
        .dout  (dout_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Decimal text for one number, pushed as the characters the block should send
    function automatic void format_decimal(input logic [VALUE_W-1:0] raw,
                                           input logic [SEL_W-1:0] sel,
                                           input logic left);
        logic [VALUE_W-1:0] v;
        logic [CHAR_W-1:0]  text[DIGITS];
        int                 positions;
        int                 first;
        int                 i;
        char_out_t          c;
        case (sel)
            SEL_8BIT:
            begin
                v = raw & 32'h0000_00FF;
                positions = 3;
            end
            SEL_16BIT:
            begin
                v = raw & 32'h0000_FFFF;
                positions = 5;
            end
            default:
            begin
                v = raw;
                positions = 10;
            end
        endcase
        for (i = 0; i < positions; i++)
            text[i] = CHAR_SPACE;
        text[positions-1] = CHAR_ZERO;
        for (i = 0; i < positions && v != 0; i++)
        begin
            text[positions-1-i] = CHAR_ZERO + CHAR_W'(v % 10);
            v = v / 10;
        end
        // left alignment drops the leading blanks, never the units digit
        first = 0;
        if (left)
            while (first < positions - 1 && text[first] == CHAR_SPACE)
                first++;
        for (i = first; i < positions; i++)
        begin
            c.character = text[i];
            c.last      = (i == positions - 1);
            pending_chars.push_back(c);
        end
    endfunction

    task automatic queue_number(input logic [VALUE_W-1:0] value, input logic [SEL_W-1:0] sel,
                                input logic left, input bit drain);
        number_req_t n;
        n.value        = value;
        n.width_select = sel;
        n.left_aligned = left;
        n.drain_first  = drain;
        pending_numbers.push_back(n);
    endtask

    // Driver: bursts of transfers with random gaps, optional drain before an item
    always @(posedge clk or negedge rst_n)
    begin : number_driver
        int          burst_left;
        int          gap_left;
        bit          show;
        number_req_t nxt;
        if (!rst_n)
        begin
            din_bus.valid        <= 1'b0;
            din_bus.value        <= '0;
            din_bus.width_select <= SEL_8BIT;
            din_bus.left_aligned <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (din_bus.valid && din_bus.ready)
            begin
                format_decimal(din_bus.value, din_bus.width_select, din_bus.left_aligned);
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 6);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
            end
            if (!din_bus.valid || din_bus.ready)
            begin
                show = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_numbers.size() != 0)
                    show = !(pending_numbers[0].drain_first && pending_chars.size() != 0);
                if (show)
                begin
                    nxt = pending_numbers.pop_front();
                    din_bus.valid        <= 1'b1;
                    din_bus.value        <= nxt.value;
                    din_bus.width_select <= nxt.width_select;
                    din_bus.left_aligned <= nxt.left_aligned;
                end
                else
                    din_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each character transfer, ready follows a changing stall mode
    always @(posedge clk or negedge rst_n)
    begin : char_monitor
        char_out_t want;
        rx_mode_t  stall_mode;
        int        mode_left;
        if (!rst_n)
        begin
            dout_bus.ready <= 1'b0;
            stall_mode = RX_OPEN;
            mode_left  = 0;
        end
        else
        begin
            if (dout_bus.valid && dout_bus.ready)
            begin
                if (pending_chars.size() == 0)
                    report_mismatch($sformatf("unexpected character %0d last %0b",
                                              dout_bus.character, dout_bus.last));
                else
                begin
                    want = pending_chars.pop_front();
                    if (dout_bus.character !== want.character)
                        report_mismatch($sformatf("character %0d, wanted %0d",
                                                  dout_bus.character, want.character));
                    if (dout_bus.last !== want.last)
                        report_mismatch($sformatf("last %0b, wanted %0b on character %0d",
                                                  dout_bus.last, want.last, want.character));
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end
            else
                mode_left--;
            case (stall_mode)
                RX_OPEN:     dout_bus.ready <= 1'b1;
                RX_LIGHT:    dout_bus.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:    dout_bus.ready <= ($urandom_range(0, 7) == 0);
                default:     dout_bus.ready <= ((cycle_count % 5) < 2);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [SEL_W-1:0]   sel;
        logic [VALUE_W-1:0] mask;
        logic [VALUE_W-1:0] mag;
        int                 bits;
        int                 positions;
        int                 k;
        int                 n;
        mismatches           = 0;
        rst_n                = 1'b0;

        // Directed: zero, full scale, ignored upper bits, spare width code
        queue_number(32'd0,          SEL_8BIT,  1'b0, 1'b0);
        queue_number(32'd0,          SEL_8BIT,  1'b1, 1'b0);
        queue_number(32'd255,        SEL_8BIT,  1'b0, 1'b0);
        queue_number(32'd255,        SEL_8BIT,  1'b1, 1'b0);
        queue_number(32'hFFFF_FF07,  SEL_8BIT,  1'b1, 1'b0);
        queue_number(32'd100,        SEL_8BIT,  1'b0, 1'b0);
        queue_number(32'd0,          SEL_16BIT, 1'b1, 1'b0);
        queue_number(32'd65535,      SEL_16BIT, 1'b0, 1'b0);
        queue_number(32'd65535,      SEL_16BIT, 1'b1, 1'b0);
        queue_number(32'h0001_2345,  SEL_16BIT, 1'b0, 1'b0);
        queue_number(32'd10000,      SEL_16BIT, 1'b1, 1'b0);
        queue_number(32'd0,          SEL_32BIT, 1'b0, 1'b0);
        queue_number(32'd0,          SEL_32BIT, 1'b1, 1'b0);
        queue_number(32'hFFFF_FFFF,  SEL_32BIT, 1'b0, 1'b0);
        queue_number(32'hFFFF_FFFF,  SEL_32BIT, 1'b1, 1'b0);
        queue_number(32'd1000000000, SEL_32BIT, 1'b0, 1'b0);
        queue_number(32'd999999999,  SEL_32BIT, 1'b1, 1'b0);
        queue_number(32'd1,          SEL_32BIT, 1'b0, 1'b0);
        queue_number(32'hFFFF_FFFF,  SEL_SPARE, 1'b0, 1'b0);
        queue_number(32'd0,          SEL_SPARE, 1'b1, 1'b0);
        queue_number(32'd42,         SEL_SPARE, 1'b0, 1'b0);

        // Random: magnitudes spread over all digit counts, junk above the width
        for (n = 0; n < RANDOM_NUMBERS; n++)
        begin
            sel = SEL_W'($urandom_range(0, 3));
            case (sel)
                SEL_8BIT:
                begin
                    bits = 8;
                    positions = 3;
                    mask = 32'h0000_00FF;
                end
                SEL_16BIT:
                begin
                    bits = 16;
                    positions = 5;
                    mask = 32'h0000_FFFF;
                end
                default:
                begin
                    bits = 32;
                    positions = 10;
                    mask = 32'hFFFF_FFFF;
                end
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                // decade boundaries: 10^k and 10^k - 1
                k = $urandom_range(1, positions - 1);
                mag = VALUE_W'(64'd10 ** k) - VALUE_W'($urandom_range(0, 1));
            end
            else
                mag = $urandom >> (32 - $urandom_range(0, bits));
            if (bits < 32 && $urandom_range(0, 1) == 1)
                mag = mag | ($urandom & ~mask);
            queue_number(mag, sel, 1'($urandom_range(0, 1)),
                         (n == 0) || ($urandom_range(0, 39) == 0));
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_numbers.size() != 0 || din_bus.valid || pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
